// ===== hw/rtl/tssp_pkg.sv =====
// Package for the toggle set with successor / predecessor queries.
// Holds the shared field widths, operation codes, sequencer states and scan control.
// No dependencies; tssp_scan and the top module import it.
`default_nettype none

package tssp_pkg;

    // Default sizing of the membership store.
    localparam int DEF_SET_SIZE  = 1024;
    localparam int DEF_WORD_BITS = 64;

    // Fixed field widths of the stream payloads.
    localparam int OP_W      = 2;
    localparam int IDX_W     = 11;
    localparam int POS_W     = 11;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Operation codes carried on the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_TOGGLE = 2'd0,
        OP_SUCC   = 2'd1,
        OP_PRED   = 2'd2
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT_Q,
        ST_SPLIT_R,
        ST_FETCH,
        ST_EXAMINE,
        ST_FINISH
    } state_t;

    // Control of the shared word scanner.
    typedef struct packed {
        logic succ;   // search upward for the lowest set bit
        logic first;  // first word of a query: apply the bound mask
    } scan_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tssp_mem.sv =====
// Membership word memory: one write port, one read port with registered data.
// Depends on nothing but its parameters.
`default_nettype none

module tssp_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data valid the cycle after the request.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tssp_scan.sv =====
// Shared word scanner: finds the lowest or highest set bit of one membership word,
// optionally bounded by a bit offset. Depends on tssp_pkg for the control struct.
`default_nettype none

module tssp_scan #(
    parameter int WORD_BITS = 64
) (
    input  wire logic [WORD_BITS-1:0]         word,
    input  wire logic [$clog2(WORD_BITS)-1:0] bound,
    input  wire tssp_pkg::scan_ctl_t          ctl,
    output logic                              hit,
    output logic [$clog2(WORD_BITS)-1:0]      offset
);

    import tssp_pkg::*;

    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] masked;
    logic [BW-1:0]        lo_off;
    logic [BW-1:0]        hi_off;

    // Keep only the bits on the searched side of the bound in the first word.
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!ctl.first) begin
                mask[i] = 1'b1;
            end else if (ctl.succ) begin
                mask[i] = (BW'(i) >= bound);
            end else begin
                mask[i] = (BW'(i) <= bound);
            end
        end
        masked = word & mask;
    end

    // Priority encoders for the lowest and the highest set bit.
    always_comb begin
        lo_off = '0;
        hi_off = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                lo_off = BW'(i);
            end
        end
        for (int i = 0; i < WORD_BITS; i++) begin
            if (masked[i]) begin
                hi_off = BW'(i);
            end
        end
    end

    assign hit    = |masked;
    assign offset = ctl.succ ? lo_off : hi_off;

endmodule

`default_nettype wire

// ===== hw/rtl/toggle_set_successor_predecessor.sv =====
// Sequence: a toggle or query passes ST_SPLIT_Q, ST_SPLIT_R and ST_FETCH to ST_EXAMINE, where a
// toggle writes its flipped word back and a query scans k = 1..NUM_WORDS words (16 at defaults),
// one word per cycle through the single memory read port and the shared word scanner. A query
// whose bound alone rules out any member skips to ST_FINISH; an ignored item leaves input ready.
// Throughput: one item at a time; a finished query waits while the output register is full.
// Reset: synchronous, active low; then a clearing pass over every word with s_axis_tready low.
`default_nettype none

module toggle_set_successor_predecessor #(
    parameter int SET_SIZE  = tssp_pkg::DEF_SET_SIZE,
    parameter int WORD_BITS = tssp_pkg::DEF_WORD_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input transactions.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [tssp_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [10:0] index
    input  wire logic [tssp_pkg::OP_W-1:0]      s_axis_tuser,  // [1:0] operation
    // Result transactions.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [tssp_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [10:0] position
    output logic      [0:0]                     m_axis_tuser   // [0] found
);

    import tssp_pkg::*;

    localparam int NUM_WORDS = (SET_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int PW        = (SET_SIZE > 2) ? $clog2(SET_SIZE) : 1;
    localparam int SZW       = $clog2(SET_SIZE + 1);
    localparam int EXTW      = (SZW > IDX_W) ? SZW : IDX_W;
    localparam int RK        = PW + 8;
    localparam int RECIP     = ((1 << RK) + WORD_BITS - 1) / WORD_BITS;
    localparam int PRW       = PW + RK;
    localparam int MW        = PW + 8;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [WA-1:0]      word_reg, word_next;
    logic [PW-1:0]      base_reg, base_next;
    logic [BW-1:0]      bit_reg, bit_next;
    logic               first_reg, first_next;
    logic [WA-1:0]      clr_reg, clr_next;
    logic               res_found_reg, res_found_next;
    logic [PW:0]        res_pos_reg, res_pos_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_found_reg, m_found_next;
    logic [POS_W-1:0]   m_pos_reg, m_pos_next;

    logic               mem_wr_en;
    logic [WA-1:0]      mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [WA-1:0]      mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;

    scan_ctl_t          scan_ctl;
    logic               scan_hit;
    logic [BW-1:0]      scan_off;

    logic [EXTW-1:0]    idx_ext;
    logic [PRW-1:0]     prod;
    logic [MW-1:0]      base_calc;
    logic               last_word;
    logic               out_load;

    // Membership store.
    tssp_mem #(
        .DEPTH  (NUM_WORDS),
        .WIDTH  (WORD_BITS),
        .ADDR_W (WA)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Shared word scanner.
    assign scan_ctl.succ  = (op_reg == OP_SUCC);
    assign scan_ctl.first = first_reg;

    tssp_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .word   (mem_rd_data),
        .bound  (bit_reg),
        .ctl    (scan_ctl),
        .hit    (scan_hit),
        .offset (scan_off)
    );

    // Word and bit split of the starting position by reciprocal multiplication.
    assign idx_ext   = EXTW'(s_axis_tdata[IDX_W-1:0]);
    assign prod      = PRW'(p_reg) * PRW'(RECIP);
    assign base_calc = MW'(word_reg) * MW'(WORD_BITS);
    assign last_word = (op_reg == OP_SUCC) ? (word_reg == WA'(NUM_WORDS - 1))
                                           : (word_reg == '0);

    // State and data registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg        <= op_next;
        p_reg         <= p_next;
        word_reg      <= word_next;
        base_reg      <= base_next;
        bit_reg       <= bit_next;
        first_reg     <= first_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

    // Sequencer: next state, memory control and result capture.
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        p_next         = p_reg;
        word_next      = word_reg;
        base_next      = base_reg;
        bit_next       = bit_reg;
        first_next     = first_reg;
        clr_next       = clr_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = word_reg;
        mem_wr_data    = mem_rd_data ^ (WORD_BITS'(1) << bit_reg);
        mem_rd_en      = 1'b0;
        mem_rd_addr    = word_reg;
        out_load       = 1'b0;
        s_axis_tready  = 1'b0;

        unique case (state_reg)
            // Zero one memory word per cycle after reset.
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = '0;
                if (clr_reg == WA'(NUM_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + WA'(1);
                end
            end

            // Take a transaction and settle the cases that need no scan.
            ST_IDLE: begin
                s_axis_tready  = 1'b1;
                res_found_next = 1'b0;
                res_pos_next   = '0;
                first_next     = 1'b1;
                if (s_axis_tvalid) begin
                    op_next = op_t'(s_axis_tuser);
                    unique case (s_axis_tuser)
                        OP_TOGGLE: begin
                            if (idx_ext != '0 && idx_ext <= EXTW'(SET_SIZE)) begin
                                p_next     = PW'(idx_ext - EXTW'(1));
                                state_next = ST_SPLIT_Q;
                            end
                        end
                        OP_SUCC: begin
                            if (idx_ext > EXTW'(SET_SIZE)) begin
                                state_next = ST_FINISH;
                            end else begin
                                p_next     = (idx_ext == '0) ? '0 : PW'(idx_ext - EXTW'(1));
                                state_next = ST_SPLIT_Q;
                            end
                        end
                        OP_PRED: begin
                            if (idx_ext == '0) begin
                                state_next = ST_FINISH;
                            end else begin
                                p_next     = (idx_ext > EXTW'(SET_SIZE)) ? PW'(SET_SIZE - 1)
                                                                          : PW'(idx_ext - EXTW'(1));
                                state_next = ST_SPLIT_Q;
                            end
                        end
                        default: begin
                            // The unused code is dropped without a result.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Word number from the reciprocal product.
            ST_SPLIT_Q: begin
                word_next  = WA'(prod >> RK);
                state_next = ST_SPLIT_R;
            end

            // Word base position and bit offset within the word.
            ST_SPLIT_R: begin
                base_next  = PW'(base_calc);
                bit_next   = BW'(p_reg - PW'(base_calc));
                state_next = ST_FETCH;
            end

            ST_FETCH: begin
                mem_rd_en  = 1'b1;
                state_next = ST_EXAMINE;
            end

            // Flip the bit, or scan the word and step to its neighbor.
            ST_EXAMINE: begin
                if (op_reg == OP_TOGGLE) begin
                    mem_wr_en  = 1'b1;
                    state_next = ST_IDLE;
                end else if (scan_hit) begin
                    res_found_next = 1'b1;
                    res_pos_next   = (PW + 1)'(base_reg) + (PW + 1)'(scan_off) + (PW + 1)'(1);
                    state_next     = ST_FINISH;
                end else if (last_word) begin
                    state_next = ST_FINISH;
                end else begin
                    first_next = 1'b0;
                    mem_rd_en  = 1'b1;
                    if (op_reg == OP_SUCC) begin
                        word_next = word_reg + WA'(1);
                        base_next = PW'(MW'(base_reg) + MW'(WORD_BITS));
                    end else begin
                        word_next = word_reg - WA'(1);
                        base_next = PW'(MW'(base_reg) - MW'(WORD_BITS));
                    end
                    mem_rd_addr = word_next;
                end
            end

            // Hand the result to the output register once it is free.
            ST_FINISH: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register, independent of the sequencer once loaded.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_found_next  = m_found_reg;
        m_pos_next    = m_pos_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_found_next  = res_found_reg;
            m_pos_next    = POS_W'(res_pos_reg);
        end else if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_pos_reg);
    assign m_axis_tuser  = m_found_reg;

`ifndef ASSERT_OFF
    // The clearing pass always keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("input ready right after reset");

    // A result that found nothing carries position zero.
    a_empty_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("not-found result with nonzero position");

    // The memory is written only by the clearing pass or a toggle.
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_CLEAR || (state_reg == ST_EXAMINE && op_reg == OP_TOGGLE)))
        else $error("unexpected memory write");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_axis_tready))
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire
